// ===== rtl/ffba_pkg.sv =====
// Package: shared types and constants for the first-fit block allocator.
`default_nettype none
package ffba_pkg;
    localparam int unsigned SIZE_W = 16;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_NO_MATCH = 2'd2
    } status_t;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_type_t;

    typedef enum logic [2:0] {
        WS_IDLE,
        WS_READ,
        WS_CHECK,
        WS_SPLIT,
        WS_OUT
    } walk_state_t;

    typedef struct packed {
        req_type_t          req_type;
        logic [SIZE_W-1:0]  req_size;
        logic [SIZE_W-1:0]  req_offset;
        logic               null_free;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [SIZE_W-1:0]  payload_offset;
        logic [SIZE_W-1:0]  granted_size;
    } rsp_t;
endpackage
`default_nettype wire

// ===== rtl/ffba_front.sv =====
// Front end: accepts request beats, classifies them, and queues them for the walker.
`default_nettype none
module ffba_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [31:0]         s_tdata,
    input  wire logic                s_tuser,
    output logic                     q_valid,
    input  wire logic                q_ready,
    output ffba_pkg::req_t           q_req
);
    import ffba_pkg::*;

    req_t q_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    req_t in_req;
    logic push, pop;

    always_comb begin
        in_req.req_type = req_type_t'(s_tuser);
        in_req.req_size = s_tdata[15:0];
        in_req.req_offset = s_tdata[31:16];
        in_req.null_free = s_tuser && (s_tdata[31:16] == '0);
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push = s_tvalid && s_tready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_req = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ffba_back.sv =====
// Back end: walks the block table one entry per step and emits one result per request.
`default_nettype none
module ffba_back #(
    parameter int unsigned MAX_BLOCKS     = 64,
    parameter int unsigned HEADER_BYTES   = 24,
    parameter int unsigned POOL_ADDR_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [15:0]         cfg_wr_data,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire ffba_pkg::req_t      q_req,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output ffba_pkg::rsp_t           m_rsp
);
    import ffba_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
    localparam int unsigned LNK_W = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned AW = (POOL_ADDR_BITS < 16) ? POOL_ADDR_BITS : 16;
    localparam logic [LNK_W-1:0] END_MARK = LNK_W'(MAX_BLOCKS);
    localparam logic [LNK_W-1:0] FULL_CNT = LNK_W'(MAX_BLOCKS);
    localparam logic [17:0] HDR = 18'(HEADER_BYTES);
    localparam logic [15:0] ADDR_MASK = 16'((17'd1 << AW) - 17'd1);

    // table memory: {start, bytes, link}; free bits in flops
    logic [15:0]      start_mem [MAX_BLOCKS];
    logic [15:0]      bytes_mem [MAX_BLOCKS];
    logic [LNK_W-1:0] link_mem  [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] free_reg, free_next;

    logic [15:0]      rd_start_reg, rd_bytes_reg;
    logic [LNK_W-1:0] rd_link_reg;

    walk_state_t state_reg, state_next;
    req_t        req_reg, req_next;
    logic [LNK_W-1:0] cur_reg, cur_next;
    logic [LNK_W-1:0] steps_reg, steps_next;
    logic [LNK_W-1:0] count_reg, count_next;
    logic [15:0] pool_reg;
    logic [15:0] bytes0;
    rsp_t  rsp_reg, rsp_next;
    logic  out_valid_reg, out_valid_next;

    logic             we;
    logic [IDX_W-1:0] wa;
    logic [15:0]      w_start, w_bytes;
    logic [LNK_W-1:0] w_link;
    logic [IDX_W-1:0] rd_addr;

    logic [17:0] need;
    logic [17:0] new_start;
    logic        fits;

    // entry 0 reset contents are loaded right after reset is released
    logic        init_pending_reg;
    logic [15:0] rst_bytes;

    assign q_ready = (state_reg == WS_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_rsp = rsp_reg;
    assign rd_addr = cur_reg[IDX_W-1:0];
    assign need = {2'b00, req_reg.req_size} + (HDR << 1);
    assign new_start = {2'b00, rd_start_reg} + HDR + {2'b00, req_reg.req_size};
    assign fits = free_reg[rd_addr] && (rd_bytes_reg >= req_reg.req_size);
    assign rst_bytes = ({2'b00, pool_reg} > HDR) ? 16'({2'b00, pool_reg} - HDR) : 16'd0;

    always_comb begin
        logic [15:0] ps;
        ps = cfg_wr_data & ADDR_MASK;
        bytes0 = ({2'b00, ps} > HDR) ? 16'({2'b00, ps} - HDR) : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == WS_READ) begin
            rd_start_reg <= start_mem[rd_addr];
            rd_bytes_reg <= bytes_mem[rd_addr];
            rd_link_reg  <= link_mem[rd_addr];
        end
        if (we) begin
            start_mem[wa] <= w_start;
            bytes_mem[wa] <= w_bytes;
            link_mem[wa]  <= w_link;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_pending_reg <= 1'b1;
        end else if (init_pending_reg) begin
            init_pending_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
        if (!aresetn) begin
            state_reg <= WS_IDLE;
            cur_reg <= '0;
            steps_reg <= '0;
            count_reg <= LNK_W'(1);
            free_reg <= MAX_BLOCKS'(1);
            out_valid_reg <= 1'b0;
            pool_reg <= 16'd4096 & ADDR_MASK;
        end else begin
            state_reg <= state_next;
            cur_reg <= cur_next;
            steps_reg <= steps_next;
            count_reg <= count_next;
            free_reg <= free_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) pool_reg <= cfg_wr_data & ADDR_MASK;
        end
    end

    always_comb begin
        state_next = state_reg;
        req_next = req_reg;
        cur_next = cur_reg;
        steps_next = steps_reg;
        count_next = count_reg;
        free_next = free_reg;
        rsp_next = rsp_reg;
        out_valid_next = out_valid_reg;
        we = 1'b0;
        wa = '0;
        w_start = '0;
        w_bytes = '0;
        w_link = '0;

        if (out_valid_reg && m_tready) out_valid_next = 1'b0;

        case (state_reg)
            WS_IDLE: begin
                if (q_valid && q_ready) begin
                    req_next = q_req;
                    cur_next = '0;
                    steps_next = '0;
                    if (q_req.null_free) begin
                        rsp_next = '{ST_OK, 16'd0, 16'd0};
                        out_valid_next = 1'b1;
                    end else begin
                        state_next = WS_READ;
                    end
                end
            end
            WS_READ: begin
                state_next = WS_CHECK;
            end
            WS_CHECK: begin
                if (req_reg.req_type == REQ_ALLOC) begin
                    if (fits) begin
                        free_next[rd_addr] = 1'b0;
                        if (({2'b00, rd_bytes_reg} > need) && (count_reg < FULL_CNT)) begin
                            state_next = WS_SPLIT;
                        end else begin
                            rsp_next = '{ST_OK, 16'({2'b00, rd_start_reg} + HDR), rd_bytes_reg};
                            out_valid_next = 1'b1;
                            state_next = WS_IDLE;
                        end
                    end else begin
                        state_next = WS_READ;
                    end
                end else begin
                    if (16'({2'b00, rd_start_reg} + HDR) == req_reg.req_offset) begin
                        free_next[rd_addr] = 1'b1;
                        rsp_next = '{ST_OK, req_reg.req_offset, rd_bytes_reg};
                        out_valid_next = 1'b1;
                        state_next = WS_IDLE;
                    end else begin
                        state_next = WS_READ;
                    end
                end
                if (state_next == WS_READ) begin
                    cur_next = rd_link_reg;
                    steps_next = steps_reg + LNK_W'(1);
                    if ((steps_reg + LNK_W'(1) >= FULL_CNT) || (rd_link_reg >= END_MARK)) begin
                        if (req_reg.req_type == REQ_ALLOC) begin
                            rsp_next = '{ST_NO_FIT, 16'd0, 16'd0};
                        end else begin
                            rsp_next = '{ST_NO_MATCH, 16'd0, 16'd0};
                        end
                        out_valid_next = 1'b1;
                        state_next = WS_IDLE;
                    end
                end
            end
            WS_SPLIT: begin
                // remainder becomes a new free entry right after this block
                we = 1'b1;
                wa = count_reg[IDX_W-1:0];
                w_start = new_start[15:0];
                w_bytes = 16'({2'b00, rd_bytes_reg} - {2'b00, req_reg.req_size} - HDR);
                w_link = rd_link_reg;
                free_next[count_reg[IDX_W-1:0]] = 1'b1;
                state_next = WS_OUT;
            end
            WS_OUT: begin
                // shrink the granted entry and link it to the new one
                we = 1'b1;
                wa = rd_addr;
                w_start = rd_start_reg;
                w_bytes = req_reg.req_size;
                w_link = count_reg;
                count_next = count_reg + LNK_W'(1);
                rsp_next = '{ST_OK, 16'({2'b00, rd_start_reg} + HDR), req_reg.req_size};
                out_valid_next = 1'b1;
                state_next = WS_IDLE;
            end
            default: begin
                state_next = WS_IDLE;
            end
        endcase

        if (init_pending_reg && aresetn) begin
            we = 1'b1;
            wa = '0;
            w_start = 16'd0;
            w_bytes = rst_bytes;
            w_link = END_MARK;
        end

        if (cfg_wr_en) begin
            we = 1'b1;
            wa = '0;
            w_start = 16'd0;
            w_bytes = bytes0;
            w_link = END_MARK;
            free_next = MAX_BLOCKS'(1);
            count_next = LNK_W'(1);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/first_fit_block_allocator_top.sv =====
// Top level: first-fit block allocator with request queue and table walker.
//
// Each request beat is queued by the front end and carried out by a walker that
// visits one table entry per step (read, then check) along the address-ordered
// chain, at most MAX_BLOCKS entries per request; a split adds the SPLIT and OUT
// write states. One request is walked at a time: the walker takes a new one only
// while idle with no result pending. A null free is answered without a walk.
// Writing pool_size rebuilds the table as one free block; the user must see that
// it is done only while the block is idle, as the block itself does not enforce
// this. The first entry is loaded right after reset, before any request reaches it.
`default_nettype none
module first_fit_block_allocator_top #(
    parameter int unsigned MAX_BLOCKS     = 64,
    parameter int unsigned HEADER_BYTES   = 24,
    parameter int unsigned POOL_ADDR_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,   // pool_size
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,       // [15:0] req_size, [31:16] req_offset
    input  wire logic        s_tuser,       // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,       // [15:0] payload_offset, [31:16] granted_size
    output logic [1:0]       m_tuser        // status
);
    import ffba_pkg::*;

    logic q_valid, q_ready;
    req_t q_req;
    rsp_t rsp;

    ffba_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .q_valid, .q_ready, .q_req
    );

    ffba_back #(
        .MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES),
        .POOL_ADDR_BITS(POOL_ADDR_BITS)
    ) u_back (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_data, .q_valid, .q_ready, .q_req,
        .m_tvalid, .m_tready, .m_rsp(rsp)
    );

    assign m_tdata = {rsp.granted_size, rsp.payload_offset};
    assign m_tuser = rsp.status;
endmodule
`default_nettype wire

// ===== tb/first_fit_block_allocator_top_test.sv =====
// Testbench: checks the first-fit block allocator against a cycle-free predictor.
`default_nettype none
module first_fit_block_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ffba_pkg::*;

    localparam int unsigned NBLK = 64;
    localparam int unsigned HDR = 24;
    localparam int unsigned IDLE_LIMIT = 20000;

    typedef struct packed {
        status_t     status;
        logic [15:0] offset;
        logic [15:0] size;
    } grant_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [15:0] req_size, [31:16] req_offset
    logic        s_tuser = 1'b0; // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [15:0] payload_offset, [31:16] granted_size
    logic [1:0]  m_tuser;        // status

    first_fit_block_allocator_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // allocator shadow
    int unsigned pool_bytes;
    int unsigned blk_start [NBLK];
    int unsigned blk_bytes [NBLK];
    bit          blk_free  [NBLK];
    int unsigned blk_link  [NBLK];
    int unsigned blk_count;

    grant_t      grant_q [$];
    logic [15:0] live_offs [$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          hold_req = 1'b0;
    int          burst_left = 0;

    function automatic void rebuild_table(int unsigned pool);
        pool_bytes = pool;
        for (int i = 0; i < NBLK; i++) begin
            blk_start[i] = 0;
            blk_bytes[i] = 0;
            blk_free[i] = 1'b0;
            blk_link[i] = 0;
        end
        blk_bytes[0] = (pool > HDR) ? pool - HDR : 0;
        blk_free[0] = 1'b1;
        blk_link[0] = NBLK;
        blk_count = 1;
    endfunction

    function automatic grant_t allocate_or_free(req_type_t kind, int unsigned size,
                                                int unsigned offset);
        grant_t      g;
        int unsigned cur;
        int unsigned nb;
        g = '{ST_OK, 16'd0, 16'd0};
        cur = 0;
        if (kind == REQ_ALLOC) begin
            for (int n = 0; n < NBLK && cur < NBLK; n++) begin
                if (blk_free[cur] && blk_bytes[cur] >= size) begin
                    if (blk_bytes[cur] > size + 2 * HDR && blk_count < NBLK) begin
                        nb = blk_count;
                        blk_start[nb] = blk_start[cur] + HDR + size;
                        blk_bytes[nb] = blk_bytes[cur] - size - HDR;
                        blk_free[nb] = 1'b1;
                        blk_link[nb] = blk_link[cur];
                        blk_link[cur] = nb;
                        blk_bytes[cur] = size;
                        blk_count++;
                    end
                    blk_free[cur] = 1'b0;
                    g.offset = 16'(blk_start[cur] + HDR);
                    g.size = 16'(blk_bytes[cur]);
                    return g;
                end
                cur = blk_link[cur];
            end
            g.status = ST_NO_FIT;
            return g;
        end
        if (offset == 0) return g;
        for (int n = 0; n < NBLK && cur < NBLK; n++) begin
            if (blk_start[cur] + HDR == offset) begin
                blk_free[cur] = 1'b1;
                g.offset = 16'(offset);
                g.size = 16'(blk_bytes[cur]);
                return g;
            end
            cur = blk_link[cur];
        end
        g.status = ST_NO_MATCH;
        return g;
    endfunction

    task automatic send_req(req_type_t kind, logic [15:0] size, logic [15:0] offset);
        grant_t g;
        g = allocate_or_free(kind, 32'(size), 32'(offset));
        grant_q.push_back(g);
        if (kind == REQ_ALLOC && g.status == ST_OK) live_offs.push_back(g.offset);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {offset, size};
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    endtask

    task automatic write_pool(logic [15:0] pool);
        s_tvalid <= 1'b0;
        while (grant_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= pool;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        rebuild_table(32'(pool));
        live_offs.delete();
        @(posedge aclk);
    endtask

    task automatic random_req();
        int unsigned pick;
        int          idx;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            send_req(REQ_ALLOC, 16'($urandom_range(0, 200)), 16'($urandom));
        end else if (pick < 62) begin
            send_req(REQ_ALLOC, 16'($urandom), 16'($urandom));
        end else if (pick < 90 && live_offs.size() > 0) begin
            idx = $urandom_range(0, live_offs.size() - 1);
            send_req(REQ_FREE, 16'($urandom), live_offs[idx]);
            live_offs.delete(idx);
        end else if (pick < 95) begin
            send_req(REQ_FREE, 16'($urandom), 16'($urandom));
        end else begin
            send_req(REQ_FREE, 16'($urandom), 16'd0);
        end
    endtask

    task automatic test_directed();
        send_req(REQ_ALLOC, 16'd0, 16'd0);
        send_req(REQ_ALLOC, 16'd100, 16'hFFFF);
        send_req(REQ_ALLOC, 16'hFFFF, 16'd0);
        send_req(REQ_FREE, 16'hFFFF, 16'd0);
        send_req(REQ_FREE, 16'd0, 16'd24);
        send_req(REQ_FREE, 16'd0, 16'd24);
        send_req(REQ_FREE, 16'd0, 16'hFFFF);
        send_req(REQ_ALLOC, 16'd4024, 16'd0);
        send_req(REQ_ALLOC, 16'd8, 16'd0);
        send_req(REQ_FREE, 16'd0, 16'd48);
        write_pool(16'd32);
        send_req(REQ_ALLOC, 16'd9, 16'd0);
        send_req(REQ_ALLOC, 16'd8, 16'd0);
        send_req(REQ_FREE, 16'd0, 16'd24);
        write_pool(16'd20);
        send_req(REQ_ALLOC, 16'd0, 16'd0);
        send_req(REQ_ALLOC, 16'd1, 16'd0);
        write_pool(16'hFFFF);
        send_req(REQ_ALLOC, 16'hFFE7, 16'd0);
        send_req(REQ_ALLOC, 16'd0, 16'd0);
        send_req(REQ_FREE, 16'd0, 16'd24);
        send_req(REQ_ALLOC, 16'hFFE8, 16'd0);
    endtask

    task automatic test_table_full();
        write_pool(16'd4096);
        for (int i = 0; i < 70; i++) send_req(REQ_ALLOC, 16'($urandom_range(0, 20)), 16'd0);
        for (int i = 0; i < 10; i++) random_req();
    endtask

    task automatic test_backpressure();
        write_pool(16'd4096);
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) random_req();
    endtask

    task automatic test_random(logic [15:0] pool, int count);
        write_pool(pool);
        for (int i = 0; i < count; i++) random_req();
    endtask

    initial begin
        rebuild_table(4096);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_table_full();
        test_backpressure();
        test_random(16'd4096, 350);
        test_random(16'hFFFF, 250);
        test_random(16'd300, 100);
        test_random(16'd32, 30);
        test_random(16'd1000, 100);
        s_tvalid <= 1'b0;
        while (grant_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // result stall pattern, with one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            if ($urandom_range(0, 15) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge aclk);
            end else begin
                case ($urandom_range(0, 7))
                    0, 1: m_tready <= 1'b0;
                    default: m_tready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        grant_t g;
        if (aresetn && m_tvalid && m_tready) begin
            if (grant_q.size() == 0) begin
                if (errors < 10) $display("unexpected result beat: %h %h", m_tuser, m_tdata);
                errors++;
            end else begin
                g = grant_q.pop_front();
                if (m_tuser !== g.status || m_tdata[15:0] !== g.offset ||
                    m_tdata[31:16] !== g.size) begin
                    if (errors < 10)
                        $display("mismatch: exp st=%0d off=%0d sz=%0d got st=%0d off=%0d sz=%0d",
                                 g.status, g.offset, g.size,
                                 m_tuser, m_tdata[15:0], m_tdata[31:16]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || grant_q.size() == 0) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end
endmodule
`default_nettype wire
